FILE: hw/rtl/closest_point_on_segment_macros.svh
// Assertion macros for the closest point on segment block
`ifndef CLOSEST_POINT_ON_SEGMENT_MACROS_SVH
`define CLOSEST_POINT_ON_SEGMENT_MACROS_SVH
`ifndef SYNTHESIS
`define CPS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CPS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/cps_pkg.sv
`timescale 1ns / 1ps
package cps_pkg;
    localparam int CW = 32;
    localparam int TB = 16;

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] az;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic signed [CW-1:0] bz;
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic signed [CW-1:0] pz;
    } t_in;

    typedef struct packed {
        logic signed [CW-1:0] qx;
        logic signed [CW-1:0] qy;
        logic signed [CW-1:0] qz;
        logic [TB:0]          seg_param;
    } t_out;
endpackage

FILE: hw/rtl/cps_div_stage.sv
`timescale 1ns / 1ps
// One restoring division step on a remainder
module cps_div_stage #(
    parameter int W = 68
) (
    input  logic [W-1:0] i_rem,
    input  logic [W-1:0] i_den,
    output logic [W-1:0] o_rem,
    output logic         o_bit
);
    logic [W:0] shl;
    logic [W:0] dif;
    assign shl = {i_rem, 1'b0};
    assign dif = shl - {1'b0, i_den};
    assign o_bit = ~dif[W];
    assign o_rem = o_bit ? dif[W-1:0] : shl[W-1:0];
endmodule

FILE: hw/rtl/closest_point_on_segment.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake          | Payload
// in      | to block  | i_valid / o_stall  | i_data (cps_pkg::t_in)
// out     | from block| o_valid / i_stall  | o_data (cps_pkg::t_out)
//
// Takes one transaction a cycle while the output is not stalled.
// Stages: differences, products, sums, compare, one stage per quotient bit,
// offset product, final add. The divider sets the depth.
// Reset clears the valid bits only; payload registers run free.
// A stall at the output freezes the whole line; o_stall mirrors it.
`include "closest_point_on_segment_macros.svh"
module closest_point_on_segment (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  cps_pkg::t_in    i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output cps_pkg::t_out   o_data
);
    localparam int COORD_WIDTH = cps_pkg::CW;
    localparam int T_FRAC_BITS = cps_pkg::TB;
    localparam int DW = COORD_WIDTH + 1;          // difference width
    localparam int PW = 2 * DW;                   // product width
    localparam int SW = PW + 2;                   // sum of three
    localparam int TW = T_FRAC_BITS + 1;
    localparam int NS = T_FRAC_BITS + 6;          // valid stages

    logic adv;
    assign adv = ~i_stall;
    assign o_stall = i_stall;

    // valid line
    logic [NS-1:0] r_v;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    // stage 1: differences
    logic signed [COORD_WIDTH-1:0] r1_a [3];
    logic signed [DW-1:0]          r1_d [3];
    logic signed [DW-1:0]          r1_e [3];
    logic signed [COORD_WIDTH-1:0] in_a [3];
    logic signed [COORD_WIDTH-1:0] in_b [3];
    logic signed [COORD_WIDTH-1:0] in_p [3];
    assign in_a[0] = COORD_WIDTH'(i_data.ax);
    assign in_a[1] = COORD_WIDTH'(i_data.ay);
    assign in_a[2] = COORD_WIDTH'(i_data.az);
    assign in_b[0] = COORD_WIDTH'(i_data.bx);
    assign in_b[1] = COORD_WIDTH'(i_data.by);
    assign in_b[2] = COORD_WIDTH'(i_data.bz);
    assign in_p[0] = COORD_WIDTH'(i_data.px);
    assign in_p[1] = COORD_WIDTH'(i_data.py);
    assign in_p[2] = COORD_WIDTH'(i_data.pz);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r1_a[k] <= in_a[k];
                r1_d[k] <= DW'(in_b[k]) - DW'(in_a[k]);
                r1_e[k] <= DW'(in_p[k]) - DW'(in_a[k]);
            end
        end
    end

    // stage 2: products
    logic signed [COORD_WIDTH-1:0] r2_a [3];
    logic signed [DW-1:0]          r2_d [3];
    logic signed [PW-1:0]          r2_n [3];
    logic signed [PW-1:0]          r2_m [3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r2_a[k] <= r1_a[k];
                r2_d[k] <= r1_d[k];
                r2_n[k] <= PW'(r1_e[k]) * PW'(r1_d[k]);
                r2_m[k] <= PW'(r1_d[k]) * PW'(r1_d[k]);
            end
        end
    end

    // stage 3: sums
    logic signed [COORD_WIDTH-1:0] r3_a [3];
    logic signed [DW-1:0]          r3_d [3];
    logic signed [SW-1:0]          r3_num;
    logic signed [SW-1:0]          r3_den;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_a   <= r2_a;
            r3_d   <= r2_d;
            r3_num <= SW'(r2_n[0]) + SW'(r2_n[1]) + SW'(r2_n[2]);
            r3_den <= SW'(r2_m[0]) + SW'(r2_m[1]) + SW'(r2_m[2]);
        end
    end

    // stage 4: classify
    logic signed [COORD_WIDTH-1:0] r4_a [3];
    logic signed [DW-1:0]          r4_d [3];
    logic [SW-1:0]                 r4_rem;
    logic [SW-1:0]                 r4_den;
    logic                          r4_lo;
    logic                          r4_hi;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_a   <= r3_a;
            r4_d   <= r3_d;
            r4_rem <= r3_num;
            r4_den <= r3_den;
            r4_lo  <= (r3_num <= 0);
            r4_hi  <= (r3_num > 0) && (r3_num >= r3_den);
        end
    end

    // divider stages: one quotient bit each
    logic signed [COORD_WIDTH-1:0] r_da [T_FRAC_BITS+1][3];
    logic signed [DW-1:0]          r_dd [T_FRAC_BITS+1][3];
    logic [SW-1:0]                 r_rem [T_FRAC_BITS+1];
    logic [SW-1:0]                 r_den [T_FRAC_BITS+1];
    logic [T_FRAC_BITS-1:0]        r_q   [T_FRAC_BITS+1];
    logic                          r_lo  [T_FRAC_BITS+1];
    logic                          r_hi  [T_FRAC_BITS+1];

    assign r_da[0]  = r4_a;
    assign r_dd[0]  = r4_d;
    assign r_rem[0] = r4_rem;
    assign r_den[0] = r4_den;
    assign r_q[0]   = '0;
    assign r_lo[0]  = r4_lo;
    assign r_hi[0]  = r4_hi;

    for (genvar g = 0; g < T_FRAC_BITS; g++) begin : g_div
        logic [SW-1:0] n_rem;
        logic          n_bit;
        logic signed [COORD_WIDTH-1:0] r_a_s [3];
        logic signed [DW-1:0]          r_d_s [3];
        logic [SW-1:0]                 r_rem_s;
        logic [SW-1:0]                 r_den_s;
        logic [T_FRAC_BITS-1:0]        r_q_s;
        logic                          r_lo_s;
        logic                          r_hi_s;
        cps_div_stage #(.W(SW)) u_step (
            .i_rem (r_rem[g]),
            .i_den (r_den[g]),
            .o_rem (n_rem),
            .o_bit (n_bit)
        );
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_a_s   <= r_da[g];
                r_d_s   <= r_dd[g];
                r_rem_s <= n_rem;
                r_den_s <= r_den[g];
                r_q_s   <= {r_q[g][T_FRAC_BITS-2:0], n_bit};
                r_lo_s  <= r_lo[g];
                r_hi_s  <= r_hi[g];
            end
        end
        assign r_da[g+1]  = r_a_s;
        assign r_dd[g+1]  = r_d_s;
        assign r_rem[g+1] = r_rem_s;
        assign r_den[g+1] = r_den_s;
        assign r_q[g+1]   = r_q_s;
        assign r_lo[g+1]  = r_lo_s;
        assign r_hi[g+1]  = r_hi_s;
    end

    // select t
    logic [TW-1:0] n_t;
    always_comb begin
        if (r_lo[T_FRAC_BITS]) begin
            n_t = '0;
        end else if (r_hi[T_FRAC_BITS]) begin
            n_t = TW'(1) << T_FRAC_BITS;
        end else begin
            n_t = {1'b0, r_q[T_FRAC_BITS]};
        end
    end

    // offset product stage
    localparam int OW = DW + TW + 1;
    logic signed [COORD_WIDTH-1:0] r5_a [3];
    logic signed [OW-1:0]          r5_o [3];
    logic [TW-1:0]                 r5_t;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_t <= n_t;
            for (int k = 0; k < 3; k++) begin
                r5_a[k] <= r_da[T_FRAC_BITS][k];
                r5_o[k] <= OW'(r_dd[T_FRAC_BITS][k]) * $signed({1'b0, n_t});
            end
        end
    end

    // final add: A + floor(d*t / 2^T)
    logic signed [OW-1:0] n_sh [3];
    logic [COORD_WIDTH-1:0] r6_q [3];
    logic [TW-1:0]          r6_t;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_sh[k] = r5_o[k] >>> T_FRAC_BITS;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_t <= r5_t;
            for (int k = 0; k < 3; k++) begin
                r6_q[k] <= r5_a[k] + n_sh[k][COORD_WIDTH-1:0];
            end
        end
    end

    assign o_valid        = r_v[NS-1];
    assign o_data.qx      = cps_pkg::CW'(r6_q[0]);
    assign o_data.qy      = cps_pkg::CW'(r6_q[1]);
    assign o_data.qz      = cps_pkg::CW'(r6_q[2]);
    assign o_data.seg_param = (cps_pkg::TB + 1)'(r6_t);

    // t never exceeds one
    `CPS_ASSERT_IMPL(a_t_range, i_clk, i_rst_n, o_valid, r6_t <= (TW'(1) << T_FRAC_BITS))
    // a stall holds the output transaction
    `CPS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))
    // clamp flags are exclusive
    `CPS_ASSERT_IMPL(a_flags, i_clk, i_rst_n, r_v[3], !(r4_lo && r4_hi))
endmodule
